// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

  // Number of entries the queue holds, one cell per entry.
  localparam int unsigned CAPACITY = 8;

  // Field widths.
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 4;

  // The entry count has to reach CAPACITY itself.
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // Operation codes of an input word.
  typedef enum logic [0:0] {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // Status codes of a result word.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // One queue entry: priority and data word.
  typedef struct packed {
    logic [PRIO_W-1:0]        prio;
    logic signed [DATA_W-1:0] data;
  } entry_t;

  // Command broadcast to every cell in a cycle.
  typedef struct packed {
    logic push;
    logic pop;
  } cell_cmd_t;

endpackage : spq_pkg

// ===== hdl/spq_cell.sv =====
`timescale 1ns / 1ps

// One slot of the sorted chain. On a push the cell keeps its entry when it
// outranks or ties the new one, otherwise it takes either the new entry or
// its left neighbor's entry. On a pop it takes its right neighbor's entry.
module spq_cell (
  input  logic              clk,
  input  spq_pkg::cell_cmd_t cmd,
  input  spq_pkg::entry_t   new_entry,
  input  logic              occupied,
  input  logic              left_ge,
  input  spq_pkg::entry_t   left_entry,
  input  spq_pkg::entry_t   right_entry,
  output logic              ge,
  output spq_pkg::entry_t   entry
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  // The held entry stays in front of the new one when its priority is at
  // least as high, which keeps equal priorities in arrival order.
  assign ge = occupied && (entry_r.prio >= new_entry.prio);

  // Choose the next content of this slot.
  always_comb begin
    entry_nxt = entry_r;
    if (cmd.push) begin
      if (ge) begin
        entry_nxt = entry_r;
      end else if (left_ge) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (cmd.pop) begin
      entry_nxt = right_entry;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule : spq_cell

// ===== hdl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps
// A result word appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle; busy stays low, since every cell of
// the chain compares and shifts in the same cycle.
// Reset: synchronous, active low; it empties the queue and clears the strobe.
// The receiver cannot stall: each result is shown for exactly one cycle.
module sorted_priority_queue (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_op,
  input  logic [spq_pkg::PRIO_W-1:0]          in_push_priority,
  input  logic signed [spq_pkg::DATA_W-1:0]   in_push_data,
  output logic                                out_valid,
  output logic [1:0]                          out_status,
  output logic [spq_pkg::PRIO_W-1:0]          out_pop_priority,
  output logic signed [spq_pkg::DATA_W-1:0]   out_pop_data,
  output logic [spq_pkg::OCC_W-1:0]           out_occupancy
);

  logic                          accept;
  logic                          push_ok;
  logic                          pop_ok;
  logic                          is_full;
  logic                          is_empty;
  logic [spq_pkg::CNT_W-1:0]     count_r;
  logic [spq_pkg::CNT_W-1:0]     count_nxt;
  spq_pkg::cell_cmd_t            cmd;
  spq_pkg::entry_t               new_entry;
  spq_pkg::entry_t               cell_entry [spq_pkg::CAPACITY];
  logic [spq_pkg::CAPACITY-1:0]  cell_ge;

  logic                          out_valid_r;
  spq_pkg::status_t              status_r;
  spq_pkg::status_t              status_nxt;
  logic [spq_pkg::PRIO_W-1:0]    pop_prio_r;
  logic [spq_pkg::PRIO_W-1:0]    pop_prio_nxt;
  logic signed [spq_pkg::DATA_W-1:0] pop_data_r;
  logic signed [spq_pkg::DATA_W-1:0] pop_data_nxt;
  logic [spq_pkg::OCC_W-1:0]     occ_r;

  // The chain finishes every word as it arrives, so the block is never busy.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign is_full  = (count_r == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
  assign is_empty = (count_r == '0);
  assign push_ok  = accept && (in_op == spq_pkg::OP_PUSH) && !is_full;
  assign pop_ok   = accept && (in_op == spq_pkg::OP_POP) && !is_empty;

  assign cmd.push  = push_ok;
  assign cmd.pop   = pop_ok;
  assign new_entry.prio = in_push_priority;
  assign new_entry.data = in_push_data;

  // Row of cells; cell 0 is the front of the queue.
  for (genvar i = 0; i < spq_pkg::CAPACITY; i++) begin : g_cell
    logic            left_ge;
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;

    if (i == 0) begin : g_first
      assign left_ge    = 1'b1;
      assign left_entry = new_entry;
    end else begin : g_inner
      assign left_ge    = cell_ge[i-1];
      assign left_entry = cell_entry[i-1];
    end

    if (i == spq_pkg::CAPACITY - 1) begin : g_last
      assign right_entry = new_entry;
    end else begin : g_body
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .new_entry   (new_entry),
      .occupied    (spq_pkg::CNT_W'(i) < count_r),
      .left_ge     (left_ge),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .ge          (cell_ge[i]),
      .entry       (cell_entry[i])
    );
  end

  // Entry count and the next result word.
  always_comb begin
    count_nxt    = count_r;
    status_nxt   = spq_pkg::ST_DONE;
    pop_prio_nxt = '0;
    pop_data_nxt = '0;
    if (push_ok) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_ok) begin
      count_nxt    = count_r - 1'b1;
      pop_prio_nxt = cell_entry[0].prio;
      pop_data_nxt = cell_entry[0].data;
    end else if (in_op == spq_pkg::OP_PUSH) begin
      status_nxt = spq_pkg::ST_FULL;
    end else begin
      status_nxt = spq_pkg::ST_EMPTY;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r   <= status_nxt;
      pop_prio_r <= pop_prio_nxt;
      pop_data_r <= pop_data_nxt;
      occ_r      <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_pop_priority = pop_prio_r;
  assign out_pop_data     = pop_data_r;
  assign out_occupancy    = occ_r;

endmodule : sorted_priority_queue

// ===== hdl/spq_checker.sv =====
`timescale 1ns / 1ps

// Port-level checks on the queue's result stream.
module spq_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic                              out_valid,
  input logic [1:0]                        out_status,
  input logic [spq_pkg::PRIO_W-1:0]        out_pop_priority,
  input logic signed [spq_pkg::DATA_W-1:0] out_pop_data,
  input logic [spq_pkg::OCC_W-1:0]         out_occupancy
);

  // Every accepted word gives a result word in the next cycle.
  a_result_follows: assert property (@(posedge clk)
    (rst_n && start && !busy) |=> out_valid)
    else $error("accepted word gave no result");

  // No result word without an accepted word in the cycle before.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(rst_n && start && !busy))
    else $error("result word without input word");

  // Rejected words carry no entry.
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != spq_pkg::ST_DONE)) |->
      ((out_pop_priority == '0) && (out_pop_data == '0)))
    else $error("rejected word carries entry fields");

  // An empty rejection reports an empty queue.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == spq_pkg::ST_EMPTY)) |-> (out_occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // A full rejection reports a full queue.
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == spq_pkg::ST_FULL)) |->
      (out_occupancy == spq_pkg::OCC_W'(spq_pkg::CAPACITY)))
    else $error("full status with wrong occupancy");

endmodule : spq_checker

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_pop_priority (out_pop_priority),
  .out_pop_data     (out_pop_data),
  .out_occupancy    (out_occupancy)
);

// ===== verif/tb_sorted_priority_queue.sv =====
`timescale 1ns / 1ps

module tb_sorted_priority_queue;

  // Run limit in clock cycles, far above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One command word as the sender presents it.
  typedef struct {
    spq_pkg::op_t                      op;
    logic [spq_pkg::PRIO_W-1:0]        prio;
    logic signed [spq_pkg::DATA_W-1:0] data;
  } cmd_word_t;

  // One result word as the queue should report it.
  typedef struct {
    spq_pkg::status_t                  status;
    logic [spq_pkg::PRIO_W-1:0]        prio;
    logic signed [spq_pkg::DATA_W-1:0] data;
    logic [spq_pkg::OCC_W-1:0]         occ;
  } result_word_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_op = 1'b0;
  logic [spq_pkg::PRIO_W-1:0]        in_push_priority = '0;
  logic signed [spq_pkg::DATA_W-1:0] in_push_data = '0;
  logic                              out_valid;
  logic [1:0]                        out_status;
  logic [spq_pkg::PRIO_W-1:0]        out_pop_priority;
  logic signed [spq_pkg::DATA_W-1:0] out_pop_data;
  logic [spq_pkg::OCC_W-1:0]         out_occupancy;

  cmd_word_t        cmd_backlog[$];
  result_word_t     expected_results[$];
  spq_pkg::entry_t  shadow_entries[$];
  int unsigned      idle_pct = 0;
  int unsigned      error_count = 0;
  int unsigned      cycle_count = 0;

  sorted_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_push_priority (in_push_priority),
    .in_push_data     (in_push_data),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_pop_priority (out_pop_priority),
    .out_pop_data     (out_pop_data),
    .out_occupancy    (out_occupancy)
  );

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one accepted word to the shadow queue and record the result it causes.
  task automatic apply_command(input spq_pkg::op_t op,
                               input logic [spq_pkg::PRIO_W-1:0] prio,
                               input logic signed [spq_pkg::DATA_W-1:0] data);
    result_word_t    res;
    spq_pkg::entry_t ent;
    int              pos;
    res.status = spq_pkg::ST_DONE;
    res.prio = '0;
    res.data = '0;
    if (op == spq_pkg::OP_PUSH) begin
      if (shadow_entries.size() >= spq_pkg::CAPACITY) begin
        res.status = spq_pkg::ST_FULL;
      end else begin
        // The new entry goes behind every entry of higher or equal priority.
        pos = 0;
        while (pos < shadow_entries.size() && shadow_entries[pos].prio >= prio)
          pos++;
        ent.prio = prio;
        ent.data = data;
        shadow_entries.insert(pos, ent);
      end
    end else begin
      if (shadow_entries.size() == 0) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        ent = shadow_entries.pop_front();
        res.prio = ent.prio;
        res.data = ent.data;
      end
    end
    res.occ = spq_pkg::OCC_W'(shadow_entries.size());
    expected_results.push_back(res);
  endtask

  // Print one field mismatch.
  task automatic report_field(input string field,
                              input logic [spq_pkg::DATA_W-1:0] exp_val,
                              input logic [spq_pkg::DATA_W-1:0] act_val);
    error_count++;
    $display("%0t: %s expected %0h actual %0h", $time, field, exp_val, act_val);
  endtask

  // Driver: records each accepted word, then presents the next one or idles.
  always @(posedge clk) begin : drive_proc
    cmd_word_t nxt;
    if (start && !busy)
      apply_command(spq_pkg::op_t'(in_op), in_push_priority, in_push_data);
    if (!(start && busy)) begin
      if (!rst_n || cmd_backlog.size() == 0 || $urandom_range(99) < idle_pct) begin
        // Idle cycle: the fields carry junk that the queue must ignore.
        start <= 1'b0;
        in_op <= 1'($urandom);
        in_push_priority <= spq_pkg::PRIO_W'($urandom);
        in_push_data <= $urandom;
      end else begin
        nxt = cmd_backlog.pop_front();
        start <= 1'b1;
        in_op <= nxt.op;
        in_push_priority <= nxt.prio;
        in_push_data <= nxt.data;
      end
    end
  end

  // Monitor: every strobed result word is checked against the oldest expectation.
  always @(posedge clk) begin : check_proc
    result_word_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result word with none expected, status %0h", $time, out_status);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_status !== exp_res.status)
          report_field("status", 32'(exp_res.status), 32'(out_status));
        if (out_pop_priority !== exp_res.prio)
          report_field("pop_priority", 32'(exp_res.prio), 32'(out_pop_priority));
        if (out_pop_data !== exp_res.data)
          report_field("pop_data", exp_res.data, out_pop_data);
        if (out_occupancy !== exp_res.occ)
          report_field("occupancy", 32'(exp_res.occ), 32'(out_occupancy));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_word(input spq_pkg::op_t op,
                            input logic [spq_pkg::PRIO_W-1:0] prio,
                            input logic signed [spq_pkg::DATA_W-1:0] data);
    cmd_word_t w;
    w.op = op;
    w.prio = prio;
    w.data = data;
    cmd_backlog.push_back(w);
  endtask

  // Random traffic in bursts that lean toward filling, draining or churning,
  // so the queue spends time full, empty and in between.
  task automatic queue_random_words(input int unsigned count);
    int unsigned                       added;
    int unsigned                       burst;
    int unsigned                       push_pct;
    spq_pkg::op_t                      op;
    logic [spq_pkg::PRIO_W-1:0]        prio;
    logic signed [spq_pkg::DATA_W-1:0] data;
    added = 0;
    while (added < count) begin
      burst = $urandom_range(24, 4);
      case ($urandom_range(3))
        0: push_pct = 85;
        1: push_pct = 15;
        2: push_pct = 50;
        default: push_pct = 60;
      endcase
      repeat (burst) begin
        op = ($urandom_range(99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP;
        // Mix of wide priorities, heavy ties and the extremes.
        case ($urandom_range(3))
          0: prio = spq_pkg::PRIO_W'($urandom);
          1: prio = spq_pkg::PRIO_W'($urandom_range(3));
          2: prio = $urandom_range(1) ? '1 : '0;
          default: prio = 16'h8000 + spq_pkg::PRIO_W'($urandom_range(7));
        endcase
        case ($urandom_range(7))
          0: data = 32'sh7fffffff;
          1: data = 32'sh80000000;
          default: data = $urandom;
        endcase
        queue_word(op, prio, data);
        added++;
      end
    end
  endtask

  // Wait until every queued word is accepted and every result has come back.
  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || start)
      @(negedge clk);
    while (expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Reset, then directed words, then random phases with different idling.
  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: empty pop, extremes, ties in arrival order, full push.
    idle_pct = 0;
    queue_word(spq_pkg::OP_POP, 16'h1234, 32'sh5a5a5a5a);
    queue_word(spq_pkg::OP_PUSH, 16'd100, 32'sd1);
    queue_word(spq_pkg::OP_PUSH, 16'd100, 32'sd2);
    queue_word(spq_pkg::OP_PUSH, 16'hffff, 32'sh7fffffff);
    queue_word(spq_pkg::OP_PUSH, 16'h0000, 32'sh80000000);
    queue_word(spq_pkg::OP_PUSH, 16'd100, 32'sd3);
    queue_word(spq_pkg::OP_PUSH, 16'd1, -32'sd1);
    queue_word(spq_pkg::OP_PUSH, 16'hffff, 32'sd0);
    queue_word(spq_pkg::OP_PUSH, 16'd200, 32'sd5);
    queue_word(spq_pkg::OP_PUSH, 16'h0000, 32'sd9);
    queue_word(spq_pkg::OP_PUSH, 16'hffff, 32'sh7fffffff);
    repeat (spq_pkg::CAPACITY) queue_word(spq_pkg::OP_POP, 16'hffff, -32'sd1);
    queue_word(spq_pkg::OP_POP, 16'h0000, 32'sd0);
    queue_word(spq_pkg::OP_PUSH, 16'h0000, 32'sh80000000);
    queue_word(spq_pkg::OP_POP, 16'h5555, 32'sh33333333);
    queue_word(spq_pkg::OP_POP, 16'haaaa, 32'shcccccccc);
    wait_drained();

    // Random phases; each ends with the sender holding off until all results are in.
    queue_random_words(260);
    wait_drained();
    idle_pct = 77;
    queue_random_words(260);
    wait_drained();
    idle_pct = 16;
    queue_random_words(260);
    wait_drained();
    idle_pct = 0;
    queue_random_words(260);
    wait_drained();

    repeat (5) @(negedge clk);
    if (error_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
